// ----- rtl/lcf_pkg.sv -----
// Package for the LSTM cell forward block: default data and fraction widths.
// No dependencies; used by lcf_act and lstm_cell_forward.
`default_nettype none

package lcf_pkg;

   // Default signed fixed-point format: Q4.12 in 16 bits
   localparam int LCF_DATA_WIDTH = 16;
   localparam int LCF_FRAC_BITS  = 12;

endpackage : lcf_pkg

`default_nettype wire

// ----- rtl/lcf_act.sv -----
// Piecewise-linear sigmoid, or tanh built as 2*sigmoid(2x) - 1, in fixed point.
// Purely combinational; depends on lcf_pkg for default widths.
`default_nettype none

module lcf_act
   import lcf_pkg::*;
#(
   parameter int IN_W      = LCF_DATA_WIDTH,
   parameter int FRAC_BITS = LCF_FRAC_BITS,
   parameter bit TANH      = 1'b0,
   parameter int OUT_W     = TANH ? FRAC_BITS + 2 : FRAC_BITS + 1
) (
   input  wire logic signed [IN_W-1:0]  x_in,
   output logic             [OUT_W-1:0] y_out
);

   localparam int AW = IN_W + 1;
   localparam int CW = (AW > FRAC_BITS + 4) ? AW : FRAC_BITS + 4;

   // Segment breakpoints and offsets
   localparam logic [CW-1:0] TH_SAT  = CW'(5)  << FRAC_BITS;
   localparam logic [CW-1:0] TH_MID  = CW'(19) << (FRAC_BITS - 3);
   localparam logic [CW-1:0] TH_ONE  = CW'(1)  << FRAC_BITS;
   localparam logic [CW-1:0] OFS_HI  = CW'(27) << (FRAC_BITS - 5);
   localparam logic [CW-1:0] OFS_MID = CW'(5)  << (FRAC_BITS - 3);
   localparam logic [CW-1:0] OFS_LO  = CW'(1)  << (FRAC_BITS - 1);
   localparam logic [FRAC_BITS:0]   ONE_S = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [FRAC_BITS+1:0] ONE_T = {2'b01, {FRAC_BITS{1'b0}}};

   logic signed [AW-1:0]  xs;
   logic                  neg;
   logic [AW-1:0]         mag;
   logic [CW-1:0]         a;
   logic [CW-1:0]         seg;
   logic [FRAC_BITS:0]    s;
   logic [FRAC_BITS:0]    sig;

   // Double the argument for tanh, then take the magnitude
   assign xs  = TANH ? {x_in, 1'b0} : {x_in[IN_W-1], x_in};
   assign neg = xs[AW-1];
   assign mag = neg ? (~xs + AW'(1)) : xs;
   assign a   = CW'(mag);

   // Pick the segment of the positive half
   always_comb begin
      if (a >= TH_SAT) begin
         seg = TH_ONE;
      end else if (a >= TH_MID) begin
         seg = (a >> 5) + OFS_HI;
      end else if (a >= TH_ONE) begin
         seg = (a >> 3) + OFS_MID;
      end else begin
         seg = (a >> 2) + OFS_LO;
      end
   end

   assign s   = seg[FRAC_BITS:0];
   // Mirror for negative arguments
   assign sig = neg ? (ONE_S - s) : s;

   generate
      if (TANH) begin : g_tanh
         assign y_out = OUT_W'({sig, 1'b0} - ONE_T);
      end else begin : g_sig
         assign y_out = OUT_W'(sig);
      end
   endgenerate

endmodule : lcf_act

`default_nettype wire

// ----- rtl/lcf_skid.sv -----
// Output register with a skid entry; decouples result backpressure from the pipeline.
// No dependencies.
`default_nettype none

module lcf_skid #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             s_valid,
   output logic                  s_ready,
   input  wire logic [WIDTH-1:0] s_data,
   output logic                  m_valid,
   input  wire logic             m_ready,
   output logic      [WIDTH-1:0] m_data
);

   logic             out_valid_ff;
   logic [WIDTH-1:0] out_data_ff;
   logic             skid_valid_ff;
   logic [WIDTH-1:0] skid_data_ff;

   assign s_ready = ~skid_valid_ff;
   assign m_valid = out_valid_ff;
   assign m_data  = out_data_ff;

   // Control: fill output register first, park in skid entry when stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (m_ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (s_valid) begin
         if (out_valid_ff && !m_ready) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (m_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Payload: no reset
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (m_ready) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (s_valid) begin
         if (out_valid_ff && !m_ready) begin
            skid_data_ff <= s_data;
         end else begin
            out_data_ff <= s_data;
         end
      end
   end

endmodule : lcf_skid

`default_nettype wire

// ----- rtl/lstm_cell_forward.sv -----
// LSTM cell forward, elementwise: gate activations, new cell and hidden value.
// Throughput: one transaction per cycle; the pipeline freezes only while the skid entry is full.
// Depth: six pipeline stages, the first loaded by the edge that accepts an input, plus the
// output register; sigmoid/tanh units and two multiplier stages set the depth.
// Reset: synchronous, active high; clears all valid bits, including the output stage's, but not the payload.
// Depends on lcf_pkg, lcf_act and lcf_skid.
`default_nettype none

module lstm_cell_forward
   import lcf_pkg::*;
#(
   parameter int DATA_WIDTH = LCF_DATA_WIDTH,
   parameter int FRAC_BITS  = LCF_FRAC_BITS,
   parameter int REQ_W      = ((5 * DATA_WIDTH + 7) / 8) * 8,
   parameter int RSP_W      = ((5 * FRAC_BITS + 7 + DATA_WIDTH + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // fields from bit 0: pre_input_gate, pre_forget_gate, pre_output_gate,
   // pre_candidate, prev_cell, zero fill
   input  wire logic [REQ_W-1:0] req_tdata,
   input  wire logic             req_tlast,  // last_in
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // fields from bit 0: act_input_gate, act_forget_gate, act_output_gate,
   // act_candidate, cell_out, hidden_out, zero fill
   output logic      [RSP_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,  // last_out
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready
);

   localparam int DW    = DATA_WIDTH;
   localparam int GW    = FRAC_BITS + 1;            // sigmoid result width
   localparam int TW    = FRAC_BITS + 2;            // tanh result width
   localparam int PF_W  = TW + DW;                  // f * c_prev
   localparam int PI_W  = TW + TW;                  // i * g
   localparam int SUM_W = ((PF_W > PI_W) ? PF_W : PI_W) + 1;
   localparam int HP_W  = TW + TW;                  // o * tanh(cell)
   localparam int OUT_BITS = 3 * GW + 2 * TW + DW;
   localparam int NSTG  = 6;

   localparam logic signed [SUM_W-1:0] HALF_S = SUM_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [HP_W-1:0]  HALF_H = HP_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [SUM_W-1:0] CMAX =
      {{(SUM_W - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
   localparam logic signed [SUM_W-1:0] CMIN =
      {{(SUM_W - DW + 1){1'b1}}, {(DW - 1){1'b0}}};
   localparam logic [GW-1:0]        ONE_G = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [TW-1:0] ONE_T = {2'b01, {FRAC_BITS{1'b0}}};

   logic                en;
   logic [NSTG-1:0]     vld_ff;
   logic [NSTG-1:0]     vld_in;

   // Stage 1: captured inputs
   logic signed [DW-1:0] xi_ff, xf_ff, xo_ff, xg_ff, cp1_ff;
   logic                 last1_ff;
   // Stage 2: activated gates
   logic [GW-1:0]        gi_in, gf_in, go_in;
   logic [TW-1:0]        gg_in;
   logic [GW-1:0]        gi2_ff, gf2_ff, go2_ff;
   logic signed [TW-1:0] gg2_ff;
   logic signed [DW-1:0] cp2_ff;
   logic                 last2_ff;
   // Stage 3: products
   logic signed [TW-1:0]   gf_s, gi_s;
   logic signed [PF_W-1:0] pf_in, pf_ff;
   logic signed [PI_W-1:0] pi_in, pi_ff;
   logic [GW-1:0]          gi3_ff, gf3_ff, go3_ff;
   logic signed [TW-1:0]   gg3_ff;
   logic                   last3_ff;
   // Stage 4: saturated cell
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] sum_sh;
   logic signed [DW-1:0]    cell_in, cell4_ff;
   logic [GW-1:0]           gi4_ff, gf4_ff, go4_ff;
   logic signed [TW-1:0]    gg4_ff;
   logic                    last4_ff;
   // Stage 5: tanh of cell
   logic [TW-1:0]           tc_in;
   logic signed [TW-1:0]    tc5_ff;
   logic signed [DW-1:0]    cell5_ff;
   logic [GW-1:0]           gi5_ff, gf5_ff, go5_ff;
   logic signed [TW-1:0]    gg5_ff;
   logic                    last5_ff;
   // Stage 6: hidden product
   logic signed [TW-1:0]    go_s;
   logic signed [HP_W-1:0]  hp_in, hp6_ff;
   logic signed [DW-1:0]    cell6_ff;
   logic [GW-1:0]           gi6_ff, gf6_ff, go6_ff;
   logic signed [TW-1:0]    gg6_ff;
   logic                    last6_ff;
   // Hidden rounding into the output register
   logic signed [HP_W-1:0]  hid_sh;
   logic [TW-1:0]           hid;
   logic [RSP_W:0]          pack;
   logic [RSP_W:0]          out_data;

   // Advance the whole pipeline while the output skid entry is free
   assign req_tready = en;
   assign vld_in     = {vld_ff[NSTG-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Activation units
   lcf_act #(.IN_W(DW), .FRAC_BITS(FRAC_BITS), .TANH(1'b0)) u_act_i (
      .x_in(xi_ff), .y_out(gi_in));
   lcf_act #(.IN_W(DW), .FRAC_BITS(FRAC_BITS), .TANH(1'b0)) u_act_f (
      .x_in(xf_ff), .y_out(gf_in));
   lcf_act #(.IN_W(DW), .FRAC_BITS(FRAC_BITS), .TANH(1'b0)) u_act_o (
      .x_in(xo_ff), .y_out(go_in));
   lcf_act #(.IN_W(DW), .FRAC_BITS(FRAC_BITS), .TANH(1'b1)) u_act_g (
      .x_in(xg_ff), .y_out(gg_in));

   // Cell products
   assign gf_s  = $signed({1'b0, gf2_ff});
   assign gi_s  = $signed({1'b0, gi2_ff});
   assign pf_in = gf_s * cp2_ff;
   assign pi_in = gi_s * gg2_ff;

   // Sum, round half up, saturate
   assign sum    = SUM_W'(pf_ff) + SUM_W'(pi_ff) + HALF_S;
   assign sum_sh = sum >>> FRAC_BITS;
   always_comb begin
      if (sum_sh > CMAX) begin
         cell_in = CMAX[DW-1:0];
      end else if (sum_sh < CMIN) begin
         cell_in = CMIN[DW-1:0];
      end else begin
         cell_in = sum_sh[DW-1:0];
      end
   end

   lcf_act #(.IN_W(DW), .FRAC_BITS(FRAC_BITS), .TANH(1'b1)) u_act_c (
      .x_in(cell4_ff), .y_out(tc_in));

   // Hidden product
   assign go_s  = $signed({1'b0, go5_ff});
   assign hp_in = go_s * tc5_ff;

   // Round hidden value
   assign hid_sh = (hp6_ff + HALF_H) >>> FRAC_BITS;
   assign hid    = hid_sh[TW-1:0];

   // Pipeline payload, advanced together with the valid bits
   always_ff @(posedge clock) begin
      if (en) begin
         xi_ff    <= req_tdata[DW-1:0];
         xf_ff    <= req_tdata[2*DW-1:DW];
         xo_ff    <= req_tdata[3*DW-1:2*DW];
         xg_ff    <= req_tdata[4*DW-1:3*DW];
         cp1_ff   <= req_tdata[5*DW-1:4*DW];
         last1_ff <= req_tlast;

         gi2_ff   <= gi_in;
         gf2_ff   <= gf_in;
         go2_ff   <= go_in;
         gg2_ff   <= gg_in;
         cp2_ff   <= cp1_ff;
         last2_ff <= last1_ff;

         pf_ff    <= pf_in;
         pi_ff    <= pi_in;
         gi3_ff   <= gi2_ff;
         gf3_ff   <= gf2_ff;
         go3_ff   <= go2_ff;
         gg3_ff   <= gg2_ff;
         last3_ff <= last2_ff;

         cell4_ff <= cell_in;
         gi4_ff   <= gi3_ff;
         gf4_ff   <= gf3_ff;
         go4_ff   <= go3_ff;
         gg4_ff   <= gg3_ff;
         last4_ff <= last3_ff;

         tc5_ff   <= tc_in;
         cell5_ff <= cell4_ff;
         gi5_ff   <= gi4_ff;
         gf5_ff   <= gf4_ff;
         go5_ff   <= go4_ff;
         gg5_ff   <= gg4_ff;
         last5_ff <= last4_ff;

         hp6_ff   <= hp_in;
         cell6_ff <= cell5_ff;
         gi6_ff   <= gi5_ff;
         gf6_ff   <= gf5_ff;
         go6_ff   <= go5_ff;
         gg6_ff   <= gg5_ff;
         last6_ff <= last5_ff;
      end
   end

   // Pack result transaction, last flag on top
   assign pack = {last6_ff, (RSP_W - OUT_BITS)'(0), hid, cell6_ff, gg6_ff,
                  go6_ff, gf6_ff, gi6_ff};

   lcf_skid #(.WIDTH(RSP_W + 1)) u_skid (
      .clock  (clock),
      .reset  (reset),
      .s_valid(vld_ff[NSTG-1] & en),
      .s_ready(en),
      .s_data (pack),
      .m_valid(rsp_tvalid),
      .m_ready(rsp_tready),
      .m_data (out_data)
   );

   assign rsp_tdata = out_data[RSP_W-1:0];
   assign rsp_tlast = out_data[RSP_W];

   // Frozen pipeline keeps its valid bits
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline valid bits moved while stalled");

   // Sigmoid results stay within 0..1
   a_gate_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[GW-1:0] <= ONE_G) && (rsp_tdata[2*GW-1:GW] <= ONE_G)
                     && (rsp_tdata[3*GW-1:2*GW] <= ONE_G))
      else $error("gate activation above one");

   // Tanh of candidate stays within -1..1
   a_tanh_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[3*GW+TW-1:3*GW]) <= ONE_T)
                     && ($signed(rsp_tdata[3*GW+TW-1:3*GW]) >= -ONE_T))
      else $error("candidate activation out of range");

endmodule : lstm_cell_forward

`default_nettype wire
